FILE: sv/htrg_pkg.sv
package htrg_pkg;

    localparam int MAX_TILE_SIZE = 4096;
    localparam int MIN_TILE_SIZE = 256;
    localparam int MAX_HALO      = 256;

    localparam int COORD_BITS = 16;
    localparam int SIZE_BITS  = 13;
    localparam int TILE_BITS  = $clog2(MAX_TILE_SIZE + 1);
    localparam int HALO_BITS  = $clog2(MAX_HALO + 1);
    localparam int ADDR_BITS  = 4;
    localparam int DATA_BITS  = 32;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TILE_SIZE    = 2'd2;
    localparam logic [1:0] REG_HALO         = 2'd3;

    localparam logic [COORD_BITS-1:0] TILE_SIZE_RESET = 16'd1024;

    typedef struct packed {
        logic [COORD_BITS-1:0] frame_w;
        logic [COORD_BITS-1:0] frame_h;
        logic [TILE_BITS-1:0]  tile;
        logic [HALO_BITS-1:0]  halo;
    } t_cfg;

    typedef struct packed {
        logic                  valid_res;
        logic [COORD_BITS-1:0] tile_x;
        logic [COORD_BITS-1:0] tile_y;
        logic [SIZE_BITS-1:0]  tile_w;
        logic [SIZE_BITS-1:0]  tile_h;
        logic [COORD_BITS-1:0] halo_x;
        logic [COORD_BITS-1:0] halo_y;
        logic [SIZE_BITS-1:0]  halo_w;
        logic [SIZE_BITS-1:0]  halo_h;
        logic                  last;
    } t_result;

endpackage

FILE: sv/htrg_cfg.sv
module htrg_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [htrg_pkg::ADDR_BITS-1:0] paddr,
    input  logic [htrg_pkg::DATA_BITS-1:0] pwdata,
    output logic [htrg_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output htrg_pkg::t_cfg                 o_cfg
);

    logic [htrg_pkg::COORD_BITS-1:0] r_frame_w;
    logic [htrg_pkg::COORD_BITS-1:0] r_frame_h;
    logic [htrg_pkg::COORD_BITS-1:0] r_tile_req;
    logic [htrg_pkg::COORD_BITS-1:0] r_halo_req;
    logic [htrg_pkg::COORD_BITS-1:0] tile_lim;
    logic [htrg_pkg::COORD_BITS-1:0] tile_edge;
    logic [htrg_pkg::TILE_BITS-1:0]  quarter;
    logic [htrg_pkg::TILE_BITS-1:0]  halo_lim;
    logic [htrg_pkg::COORD_BITS-1:0] rd_val;
    logic                            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w  <= '0;
            r_frame_h  <= '0;
            r_tile_req <= htrg_pkg::TILE_SIZE_RESET;
            r_halo_req <= '0;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                htrg_pkg::REG_FRAME_WIDTH:  r_frame_w  <= pwdata[15:0];
                htrg_pkg::REG_FRAME_HEIGHT: r_frame_h  <= pwdata[15:0];
                htrg_pkg::REG_TILE_SIZE:    r_tile_req <= pwdata[15:0];
                htrg_pkg::REG_HALO:         r_halo_req <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            htrg_pkg::REG_FRAME_WIDTH:  rd_val = r_frame_w;
            htrg_pkg::REG_FRAME_HEIGHT: rd_val = r_frame_h;
            htrg_pkg::REG_TILE_SIZE:    rd_val = r_tile_req;
            htrg_pkg::REG_HALO:         rd_val = r_halo_req;
            default:                    rd_val = '0;
        endcase
    end

    assign prdata = {{(htrg_pkg::DATA_BITS - htrg_pkg::COORD_BITS){1'b0}}, rd_val};

    always_comb begin
        tile_lim  = (r_tile_req > 16'(htrg_pkg::MAX_TILE_SIZE))
                    ? 16'(htrg_pkg::MAX_TILE_SIZE) : r_tile_req;
        tile_edge = (tile_lim < 16'(htrg_pkg::MIN_TILE_SIZE))
                    ? 16'(htrg_pkg::MIN_TILE_SIZE) : tile_lim;
        quarter   = htrg_pkg::TILE_BITS'(tile_edge >> 2);
        halo_lim  = (quarter > htrg_pkg::TILE_BITS'(htrg_pkg::MAX_HALO))
                    ? htrg_pkg::TILE_BITS'(htrg_pkg::MAX_HALO) : quarter;
        o_cfg.frame_w = r_frame_w;
        o_cfg.frame_h = r_frame_h;
        o_cfg.tile    = htrg_pkg::TILE_BITS'(tile_edge);
        o_cfg.halo    = (r_halo_req > 16'(halo_lim))
                        ? htrg_pkg::HALO_BITS'(halo_lim)
                        : htrg_pkg::HALO_BITS'(r_halo_req);
    end

endmodule

FILE: sv/htrg_walk.sv
module htrg_walk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  htrg_pkg::t_cfg     i_cfg,
    input  logic               i_accept,
    input  logic               i_restart,
    output htrg_pkg::t_result  o_result
);

    logic [15:0] r_cursor_x;
    logic [15:0] r_cursor_y;
    logic        r_walk_done;
    logic [15:0] n_cursor_x;
    logic [15:0] n_cursor_y;
    logic        n_walk_done;

    logic [15:0] cur_x;
    logic [15:0] cur_y;
    logic        done_now;
    logic        empty;
    logic [15:0] rem_x;
    logic [15:0] rem_y;
    logic [12:0] cw;
    logic [12:0] ch;
    logic [15:0] hx;
    logic [15:0] hy;
    logic [17:0] ext_x;
    logic [17:0] ext_y;
    logic [15:0] hmx;
    logic [15:0] hmy;
    logic [15:0] span_x;
    logic [15:0] span_y;
    logic [16:0] nx;
    logic [16:0] ny;
    logic        wrap_x;
    logic        wrap_y;
    logic [15:0] tile16;
    logic [15:0] halo16;

    always_comb begin
        tile16   = 16'(i_cfg.tile);
        halo16   = 16'(i_cfg.halo);
        cur_x    = i_restart ? '0 : r_cursor_x;
        cur_y    = i_restart ? '0 : r_cursor_y;
        done_now = i_restart ? 1'b0 : r_walk_done;
        empty    = (i_cfg.frame_w == '0) || (i_cfg.frame_h == '0) || done_now
                   || (cur_x >= i_cfg.frame_w) || (cur_y >= i_cfg.frame_h);

        rem_x = i_cfg.frame_w - cur_x;
        rem_y = i_cfg.frame_h - cur_y;
        cw    = (rem_x > tile16) ? 13'(i_cfg.tile) : rem_x[12:0];
        ch    = (rem_y > tile16) ? 13'(i_cfg.tile) : rem_y[12:0];
        hx    = (cur_x > halo16) ? cur_x - halo16 : '0;
        hy    = (cur_y > halo16) ? cur_y - halo16 : '0;
        ext_x = 18'(cur_x) + 18'(cw) + 18'(i_cfg.halo);
        ext_y = 18'(cur_y) + 18'(ch) + 18'(i_cfg.halo);
        hmx   = (ext_x > 18'(i_cfg.frame_w)) ? i_cfg.frame_w : ext_x[15:0];
        hmy   = (ext_y > 18'(i_cfg.frame_h)) ? i_cfg.frame_h : ext_y[15:0];
        span_x = (hmx > hx) ? hmx - hx : '0;
        span_y = (hmy > hy) ? hmy - hy : '0;

        nx     = 17'(cur_x) + 17'(i_cfg.tile);
        ny     = 17'(cur_y) + 17'(i_cfg.tile);
        wrap_x = nx >= 17'(i_cfg.frame_w);
        wrap_y = ny >= 17'(i_cfg.frame_h);

        n_cursor_x  = cur_x;
        n_cursor_y  = cur_y;
        n_walk_done = 1'b1;
        if (!empty) begin
            n_walk_done = 1'b0;
            if (wrap_x) begin
                n_cursor_x = '0;
                if (wrap_y) begin
                    n_cursor_y  = '0;
                    n_walk_done = 1'b1;
                end else begin
                    n_cursor_y = ny[15:0];
                end
            end else begin
                n_cursor_x = nx[15:0];
            end
        end

        o_result = '0;
        if (!empty) begin
            o_result.valid_res = 1'b1;
            o_result.tile_x    = cur_x;
            o_result.tile_y    = cur_y;
            o_result.tile_w    = cw;
            o_result.tile_h    = ch;
            o_result.halo_x    = hx;
            o_result.halo_y    = hy;
            o_result.halo_w    = (span_x == '0) ? 13'd1 : span_x[12:0];
            o_result.halo_h    = (span_y == '0) ? 13'd1 : span_y[12:0];
            o_result.last      = wrap_x & wrap_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x  <= '0;
            r_cursor_y  <= '0;
            r_walk_done <= 1'b1;
        end else if (i_accept) begin
            r_cursor_x  <= n_cursor_x;
            r_cursor_y  <= n_cursor_y;
            r_walk_done <= n_walk_done;
        end
    end

endmodule

FILE: sv/halo_tile_rect_generator.sv
// One request is taken per clock cycle and its tile comes out of the output
// register on the next cycle; the only limit on rate is the single output
// register, so o_stall rises only while a finished tile is held by i_stall.
// A request with i_restart high starts the row-major walk at the first tile,
// and a request after the last tile, or on a frame with zero width or height,
// returns o_valid_res low with all other fields zero. Configuration is read
// live, so it should be written only while no request is in flight.
module halo_tile_rect_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [htrg_pkg::ADDR_BITS-1:0] paddr,
    input  logic [htrg_pkg::DATA_BITS-1:0] pwdata,
    output logic [htrg_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_restart,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_valid_res,
    output logic [15:0]                    o_tile_x,
    output logic [15:0]                    o_tile_y,
    output logic [12:0]                    o_tile_w,
    output logic [12:0]                    o_tile_h,
    output logic [15:0]                    o_halo_x,
    output logic [15:0]                    o_halo_y,
    output logic [12:0]                    o_halo_w,
    output logic [12:0]                    o_halo_h,
    output logic                           o_last
);

    htrg_pkg::t_cfg    cfg;
    htrg_pkg::t_result result;
    htrg_pkg::t_result r_result;
    logic              r_valid;
    logic              accept;

    htrg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    htrg_walk u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_accept  (accept),
        .i_restart (i_restart),
        .o_result  (result)
    );

    assign o_stall = r_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= result;
        end
    end

    assign o_valid     = r_valid;
    assign o_valid_res = r_result.valid_res;
    assign o_tile_x    = r_result.tile_x;
    assign o_tile_y    = r_result.tile_y;
    assign o_tile_w    = r_result.tile_w;
    assign o_tile_h    = r_result.tile_h;
    assign o_halo_x    = r_result.halo_x;
    assign o_halo_y    = r_result.halo_y;
    assign o_halo_w    = r_result.halo_w;
    assign o_halo_h    = r_result.halo_h;
    assign o_last      = r_result.last;

endmodule

FILE: sv/htrg_checker.sv
module htrg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_valid_res,
    input logic [15:0] o_tile_x,
    input logic [15:0] o_tile_y,
    input logic [12:0] o_tile_w,
    input logic [12:0] o_tile_h,
    input logic [15:0] o_halo_x,
    input logic [15:0] o_halo_y,
    input logic [12:0] o_halo_w,
    input logic [12:0] o_halo_h,
    input logic        o_last
);

    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_tile_x) && $stable(o_tile_y)
            && $stable(o_valid_res) && $stable(o_last) && $stable(o_halo_w))
        else $error("stalled tile changed");

    a_request_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid)
        else $error("accepted request gave no tile");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_valid_res |-> o_tile_x == 16'd0 && o_tile_y == 16'd0
            && o_tile_w == 13'd0 && o_tile_h == 13'd0 && o_halo_w == 13'd0
            && o_halo_h == 13'd0 && !o_last)
        else $error("empty result has nonzero fields");

    a_halo_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_valid_res |-> o_halo_x <= o_tile_x && o_halo_y <= o_tile_y
            && o_halo_w >= o_tile_w && o_halo_h >= o_tile_h
            && o_tile_w != 13'd0 && o_tile_h != 13'd0)
        else $error("halo does not cover tile");

endmodule

bind halo_tile_rect_generator htrg_checker u_checker (.*);
